@@ hw/rtl/flr_pkg.sv @@
`timescale 1ns / 1ps

package flr_pkg;

  // Input item kinds
  typedef enum logic [2:0] {
    KIND_BYTE     = 3'd0,
    KIND_TICK     = 3'd1,
    KIND_OPEN     = 3'd2,
    KIND_VERIFIED = 3'd3,
    KIND_CLOSE    = 3'd4
  } kind_e;

  // Result events
  typedef enum logic [2:0] {
    EV_HEADER    = 3'd0,
    EV_BODY      = 3'd1,
    EV_HEARTBEAT = 3'd2,
    EV_CLOSED    = 3'd3,
    EV_REMOVE    = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    WHY_REQUESTED  = 2'd0,
    WHY_OVERSIZE   = 2'd1,
    WHY_VERIFY_TO  = 2'd2,
    WHY_HB_TO      = 2'd3
  } reason_e;

  typedef enum logic [1:0] {
    CFG_MAX_BODY   = 2'd0,
    CFG_CHECK_BODY = 2'd1,
    CFG_VERIFY_TO  = 2'd2,
    CFG_HB_TO      = 2'd3
  } cfg_idx_e;

  localparam int unsigned HDR_LEN    = 10;
  localparam int unsigned HB_PERIOD  = 10;
  localparam int unsigned LINGER_MAX = 10;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] time_sec;
    logic        passive_link;
    logic [7:0]  close_wait;
  } item_t;

  typedef struct packed {
    logic [15:0] max_body_len;
    logic        check_body_size;
    logic [31:0] verify_limit;
    logic [31:0] hb_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] pkt_size;
    logic [31:0] pkt_id;
    logic [31:0] pkt_seq;
    logic [7:0]  body_byte;
    logic        last;
    logic [1:0]  close_reason;
  } res_t;

endpackage

@@ hw/rtl/flr_engine.sv @@
`timescale 1ns / 1ps

module flr_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  flr_pkg::item_t item_i,
  input  flr_pkg::cfg_t  cfg_i,
  output logic           res_valid_o,
  output flr_pkg::res_t  res_o
);

  typedef enum logic [1:0] {
    LINK_CLOSED = 2'd0,
    LINK_VERIFY = 2'd1,
    LINK_NORMAL = 2'd2
  } link_e;

  link_e       status_q, status_d;
  logic        removed_q, removed_d;
  logic        passive_q, passive_d;
  logic [31:0] tick_q, tick_d;
  logic [3:0]  phase_q, phase_d;   // tick_q mod HB_PERIOD
  logic [3:0]  linger_q, linger_d;
  logic [31:0] open_time_q, open_time_d;
  logic [79:0] hdr_q, hdr_d;
  logic [15:0] byte_cnt_q, byte_cnt_d;
  logic        in_body_q, in_body_d;

  always_comb begin
    logic [79:0] hdr_new;
    logic [15:0] h_size;
    logic [31:0] h_id;
    logic [31:0] h_seq;
    logic [16:0] cnt_inc;
    logic [31:0] tick_inc;
    logic [3:0]  phase_inc;
    logic [31:0] deadline;
    logic        hb_done;
    logic        close_req;
    logic [7:0]  close_wait;
    logic [1:0]  close_why;

    status_d    = status_q;
    removed_d   = removed_q;
    passive_d   = passive_q;
    tick_d      = tick_q;
    phase_d     = phase_q;
    linger_d    = linger_q;
    open_time_d = open_time_q;
    hdr_d       = hdr_q;
    byte_cnt_d  = byte_cnt_q;
    in_body_d   = in_body_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    hb_done     = 1'b0;
    close_req   = 1'b0;
    close_wait  = '0;
    close_why   = flr_pkg::WHY_REQUESTED;

    hdr_new  = {hdr_q[71:0], item_i.data_byte};
    h_size   = in_body_q ? hdr_q[79:64] : hdr_new[79:64];
    h_id     = in_body_q ? hdr_q[63:32] : hdr_new[63:32];
    h_seq    = in_body_q ? hdr_q[31:0]  : hdr_new[31:0];
    cnt_inc  = {1'b0, byte_cnt_q} + 17'd1;
    tick_inc = tick_q + 32'd1;
    deadline = open_time_q + cfg_i.verify_limit;
    if (tick_q == '1) begin
      phase_inc = '0;
    end else if (phase_q == 4'(flr_pkg::HB_PERIOD - 1)) begin
      phase_inc = '0;
    end else begin
      phase_inc = phase_q + 4'd1;
    end

    if (step_i) begin
      case (item_i.kind)
        flr_pkg::KIND_BYTE: begin
          if (status_q != LINK_CLOSED) begin
            if (!in_body_q) begin
              hdr_d = hdr_new;
              if (byte_cnt_q == 16'(flr_pkg::HDR_LEN - 1)) begin
                byte_cnt_d = '0;
                if (cfg_i.check_body_size && (h_size > cfg_i.max_body_len)) begin
                  close_req = 1'b1;
                  close_why = flr_pkg::WHY_OVERSIZE;
                end else if (h_size == '0) begin
                  if (h_id == '0) begin
                    hb_done = 1'b1;
                  end else begin
                    res_valid_o        = 1'b1;
                    res_o.event_res    = flr_pkg::EV_HEADER;
                    res_o.pkt_id       = h_id;
                    res_o.pkt_seq      = h_seq;
                    res_o.last         = 1'b1;
                  end
                end else begin
                  in_body_d = 1'b1;
                  if (h_id != '0) begin
                    res_valid_o        = 1'b1;
                    res_o.event_res    = flr_pkg::EV_HEADER;
                    res_o.pkt_size     = h_size;
                    res_o.pkt_id       = h_id;
                    res_o.pkt_seq      = h_seq;
                  end
                end
              end else begin
                byte_cnt_d = cnt_inc[15:0];
              end
            end else begin
              if (cnt_inc >= {1'b0, h_size}) begin
                in_body_d  = 1'b0;
                byte_cnt_d = '0;
                if (h_id == '0) begin
                  hb_done = 1'b1;
                end else begin
                  res_valid_o     = 1'b1;
                  res_o.event_res = flr_pkg::EV_BODY;
                  res_o.pkt_size  = h_size;
                  res_o.pkt_id    = h_id;
                  res_o.pkt_seq   = h_seq;
                  res_o.body_byte = item_i.data_byte;
                  res_o.last      = 1'b1;
                end
              end else begin
                byte_cnt_d = cnt_inc[15:0];
                if (h_id != '0) begin
                  res_valid_o     = 1'b1;
                  res_o.event_res = flr_pkg::EV_BODY;
                  res_o.pkt_size  = h_size;
                  res_o.pkt_id    = h_id;
                  res_o.pkt_seq   = h_seq;
                  res_o.body_byte = item_i.data_byte;
                end
              end
            end
          end
        end
        flr_pkg::KIND_TICK: begin
          tick_d  = tick_inc;
          phase_d = phase_inc;
          if (status_q == LINK_CLOSED) begin
            if (!removed_q && (tick_inc > {28'd0, linger_q})) begin
              removed_d       = 1'b1;
              res_valid_o     = 1'b1;
              res_o.event_res = flr_pkg::EV_REMOVE;
            end
          end else if ((status_q == LINK_VERIFY) && (item_i.time_sec > deadline)) begin
            close_req = 1'b1;
            close_why = flr_pkg::WHY_VERIFY_TO;
          end else if (tick_inc > cfg_i.hb_limit) begin
            close_req = 1'b1;
            close_why = flr_pkg::WHY_HB_TO;
          end else if (passive_q && (phase_inc == '0)) begin
            res_valid_o     = 1'b1;
            res_o.event_res = flr_pkg::EV_HEARTBEAT;
            res_o.last      = 1'b1;
          end
        end
        flr_pkg::KIND_OPEN: begin
          if (status_q == LINK_CLOSED) begin
            open_time_d = item_i.time_sec;
            tick_d      = '0;
            phase_d     = '0;
            linger_d    = '0;
            passive_d   = item_i.passive_link;
            byte_cnt_d  = '0;
            in_body_d   = 1'b0;
            removed_d   = 1'b0;
            status_d    = LINK_VERIFY;
          end
        end
        flr_pkg::KIND_VERIFIED: begin
          if (status_q == LINK_VERIFY) begin
            status_d = LINK_NORMAL;
          end
        end
        flr_pkg::KIND_CLOSE: begin
          close_req  = 1'b1;
          close_wait = item_i.close_wait;
          close_why  = flr_pkg::WHY_REQUESTED;
        end
        default: begin
        end
      endcase
    end

    // completed heartbeat frame: restart liveness, echo on active links
    if (hb_done) begin
      tick_d  = '0;
      phase_d = '0;
      if (!passive_q) begin
        res_valid_o     = 1'b1;
        res_o.event_res = flr_pkg::EV_HEARTBEAT;
        res_o.pkt_size  = h_size;
        res_o.pkt_seq   = h_seq;
        res_o.last      = 1'b1;
      end
    end

    if (close_req && (status_q != LINK_CLOSED)) begin
      status_d = LINK_CLOSED;
      tick_d   = '0;
      phase_d  = '0;
      linger_d = (close_wait > 8'(flr_pkg::LINGER_MAX)) ? 4'(flr_pkg::LINGER_MAX)
                                                         : close_wait[3:0];
      res_valid_o        = 1'b1;
      res_o.event_res    = flr_pkg::EV_CLOSED;
      res_o.close_reason = close_why;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= LINK_CLOSED;
      removed_q   <= 1'b1;
      passive_q   <= 1'b0;
      tick_q      <= '0;
      phase_q     <= '0;
      linger_q    <= '0;
      open_time_q <= '0;
      byte_cnt_q  <= '0;
      in_body_q   <= 1'b0;
    end else begin
      status_q    <= status_d;
      removed_q   <= removed_d;
      passive_q   <= passive_d;
      tick_q      <= tick_d;
      phase_q     <= phase_d;
      linger_q    <= linger_d;
      open_time_q <= open_time_d;
      byte_cnt_q  <= byte_cnt_d;
      in_body_q   <= in_body_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

endmodule

@@ hw/rtl/framed_link_receiver_with_liveness.sv @@
`timescale 1ns / 1ps

// Receiver for one framed link with liveness tracking. Each input item (link
// byte, one-second tick, open, verified, close) is captured in an input
// register, processed by combinational logic and its result, if any, lands in
// an output register. One item is taken per clock; a result is registered in
// the output register as its item leaves the input register, and transfers
// when out_stall_i is low. Throughput drops below one per clock only while the
// output register is held by out_stall_i. Ten header bytes build a big-endian
// header (size, id, sequence); id 0 frames are heartbeats and are consumed.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i; the
// user must write it only while no item is in flight (not enforced here).
module framed_link_receiver_with_liveness (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] time_sec_i,
  input  logic        passive_link_i,
  input  logic [7:0]  close_wait_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [15:0] pkt_size_o,
  output logic [31:0] pkt_id_o,
  output logic [31:0] pkt_seq_o,
  output logic [7:0]  body_byte_o,
  output logic        last_o,
  output logic [1:0]  close_reason_o
);

  flr_pkg::cfg_t  cfg_q;
  flr_pkg::item_t item_q;
  logic           in_vld_q;
  logic           out_vld_q;
  flr_pkg::res_t  res_q;
  flr_pkg::res_t  res;
  logic           res_valid;
  logic           out_free;
  logic           step;
  logic           in_xfer;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !step;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_body_len    <= 16'd8192;
      cfg_q.check_body_size <= 1'b1;
      cfg_q.verify_limit    <= 32'd30;
      cfg_q.hb_limit        <= 32'd60;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        flr_pkg::CFG_MAX_BODY:   cfg_q.max_body_len    <= cfg_data_i[15:0];
        flr_pkg::CFG_CHECK_BODY: cfg_q.check_body_size <= cfg_data_i[0];
        flr_pkg::CFG_VERIFY_TO:  cfg_q.verify_limit    <= cfg_data_i;
        flr_pkg::CFG_HB_TO:      cfg_q.hb_limit        <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
      if (out_free) begin
        out_vld_q <= step && res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.kind         <= kind_i;
      item_q.data_byte    <= data_byte_i;
      item_q.time_sec     <= time_sec_i;
      item_q.passive_link <= passive_link_i;
      item_q.close_wait   <= close_wait_i;
    end
    if (step && res_valid) begin
      res_q <= res;
    end
  end

  flr_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_valid_o    = out_vld_q;
  assign event_res_o    = res_q.event_res;
  assign pkt_size_o     = res_q.pkt_size;
  assign pkt_id_o       = res_q.pkt_id;
  assign pkt_seq_o      = res_q.pkt_seq;
  assign body_byte_o    = res_q.body_byte;
  assign last_o         = res_q.last;
  assign close_reason_o = res_q.close_reason;

`ifndef SYNTHESIS
  // zero-length frame header always closes the frame
  a_empty_hdr_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_res_o == flr_pkg::EV_HEADER && pkt_size_o == 16'd0) |-> last_o)
    else $error("zero-length header without last");

  a_hb_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_res_o == flr_pkg::EV_HEARTBEAT) |-> (last_o && pkt_id_o == 32'd0))
    else $error("heartbeat result with bad fields");

  a_remove_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_res_o == flr_pkg::EV_REMOVE) |->
      (close_reason_o == flr_pkg::WHY_REQUESTED && pkt_size_o == 16'd0 && !last_o))
    else $error("remove result carries frame data");

  // a stalled input item must not be lost while the result side is busy
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !step) |=> in_vld_q)
    else $error("pending input item dropped");
`endif

endmodule
